@@ design/nsf_pkg.sv @@
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared types, character codes, verdict and kind codes, and helper
// functions for the NMEA sentence framer.
// ----------------------------------------------------------------------------
package nsf_pkg;

    localparam int LINE_CAPACITY_DEF = 128;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] MIN_CONTENT = 8'd9;

    localparam logic [1:0] VERDICT_NONE     = 2'd0;
    localparam logic [1:0] VERDICT_BAD      = 2'd1;
    localparam logic [1:0] VERDICT_MISMATCH = 2'd2;
    localparam logic [1:0] VERDICT_OK       = 2'd3;

    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_GGA   = 3'd1;
    localparam logic [2:0] KIND_GLL   = 3'd2;
    localparam logic [2:0] KIND_RMC   = 3'd3;
    localparam logic [2:0] KIND_VTG   = 3'd4;
    localparam logic [2:0] KIND_GSV   = 3'd5;
    localparam logic [2:0] KIND_GSA   = 3'd6;

    typedef struct packed {
        logic [7:0]      count;
        logic [7:0]      xsum;
        logic [5:0][7:0] head;
        logic [2:0][7:0] tail;
        logic            zero_seen;
        logic [7:0]      clen;
    } line_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] kind;
        logic       astral;
        logic [7:0] length;
    } result_t;

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

    function automatic logic is_astral(input logic [5:0][7:0] h);
        return h[0] == 8'h41 && h[1] == 8'h53 && h[2] == 8'h54 &&
               h[3] == 8'h52 && h[4] == 8'h41 && h[5] == 8'h4C;
    endfunction

    // Classifies the five bytes after the leading dollar sign.
    function automatic logic [2:0] kind_of(input logic [5:0][7:0] h);
        logic [2:0] k;
        k = KIND_OTHER;
        if (h[1] == 8'h47 && h[2] == 8'h50) begin
            if (h[3] == 8'h47 && h[4] == 8'h47 && h[5] == 8'h41)
                k = KIND_GGA;
            else if (h[3] == 8'h47 && h[4] == 8'h4C && h[5] == 8'h4C)
                k = KIND_GLL;
            else if (h[3] == 8'h52 && h[4] == 8'h4D && h[5] == 8'h43)
                k = KIND_RMC;
            else if (h[3] == 8'h56 && h[4] == 8'h54 && h[5] == 8'h47)
                k = KIND_VTG;
            else if (h[3] == 8'h47 && h[4] == 8'h53 && h[5] == 8'h56)
                k = KIND_GSV;
            else if (h[3] == 8'h47 && h[4] == 8'h53 && h[5] == 8'h41)
                k = KIND_GSA;
        end
        return k;
    endfunction

endpackage

@@ design/nmea_sentence_framer.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_framer
// A line feed is registered into the byte register, and its result is then registered into the result register.
// Throughput: one byte per cycle; a waiting result stalls only a line feed.
// Reset clears the line store and both handshake stages at once.
// ----------------------------------------------------------------------------
module nmea_sentence_framer #(
    parameter int LINE_CAPACITY = nsf_pkg::LINE_CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] verdict,
    output logic [2:0] sentence_kind,
    output logic       send_astral_reply,
    output logic [7:0] line_length
);

    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             out_valid_reg;
    nsf_pkg::result_t res_reg;
    nsf_pkg::result_t res;
    nsf_pkg::line_t   line_now;
    logic             is_lf;
    logic             is_cr;
    logic             out_free;
    logic             go;
    logic             in_take;

    assign is_lf    = byte_reg == nsf_pkg::CH_LF;
    assign is_cr    = byte_reg == nsf_pkg::CH_CR;
    assign out_free = !out_valid_reg || !out_stall;
    assign go       = in_valid_reg && (!is_lf || out_free);
    assign in_stall = in_valid_reg && !go;
    assign in_take  = in_valid && !in_stall;

    nsf_line_state #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (go && !is_cr),
        .rx_byte  (byte_reg),
        .line_now (line_now)
    );

    nsf_judge u_judge (
        .line_now (line_now),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (go)
                in_valid_reg <= 1'b0;
            if (go && is_lf)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= rx_byte;
        if (go && is_lf)
            res_reg <= res;
    end

    assign out_valid         = out_valid_reg;
    assign verdict           = res_reg.verdict;
    assign sentence_kind     = res_reg.kind;
    assign send_astral_reply = res_reg.astral;
    assign line_length       = res_reg.length;

endmodule

@@ design/nsf_line_state.sv @@
// ----------------------------------------------------------------------------
// nsf_line_state
// Line store: byte count, running XOR, head and tail bytes, zero mark and
// content length, with the full-store clear applied ahead of each byte.
// ----------------------------------------------------------------------------
module nsf_line_state #(
    parameter int LINE_CAPACITY = nsf_pkg::LINE_CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output nsf_pkg::line_t    line_now
);

    nsf_pkg::line_t line_reg;
    nsf_pkg::line_t line_next;
    nsf_pkg::line_t line_eff;
    logic           full;

    assign full     = line_reg.count >= 8'(LINE_CAPACITY);
    assign line_eff = full ? '0 : line_reg;
    assign line_now = line_eff;

    always_comb
    begin
        line_next = line_eff;
        if (rx_byte == nsf_pkg::CH_LF) begin
            line_next = '0;
        end
        else begin
            for (int i = 0; i < 6; i++) begin
                if (line_eff.count == 8'(i))
                    line_next.head[i] = rx_byte;
            end
            if (!line_eff.zero_seen) begin
                if (rx_byte == 8'd0) begin
                    line_next.zero_seen = 1'b1;
                end
                else begin
                    line_next.tail[0] = line_eff.tail[1];
                    line_next.tail[1] = line_eff.tail[2];
                    line_next.tail[2] = rx_byte;
                    line_next.clen    = line_eff.clen + 8'd1;
                end
            end
            line_next.xsum  = line_eff.xsum ^ rx_byte;
            line_next.count = line_eff.count + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_reg <= '0;
        else if (step)
            line_reg <= line_next;
    end

endmodule

@@ design/nsf_judge.sv @@
// ----------------------------------------------------------------------------
// nsf_judge
// Verdict logic for a completed line: framing, checksum check,
// sentence classification and astral reply detection.
// ----------------------------------------------------------------------------
module nsf_judge (
    input  nsf_pkg::line_t   line_now,
    output nsf_pkg::result_t res
);

    logic [7:0] sum;
    logic [4:0] hi;
    logic [4:0] lo;

    assign sum = line_now.xsum ^ nsf_pkg::CH_DOLLAR ^ nsf_pkg::CH_STAR ^
                 line_now.tail[1] ^ line_now.tail[2];
    assign hi  = nsf_pkg::hex_value(line_now.tail[1]);
    assign lo  = nsf_pkg::hex_value(line_now.tail[2]);

    always_comb
    begin
        res        = '0;
        res.length = line_now.clen;
        if (line_now.count == 8'd0 || line_now.head[0] != nsf_pkg::CH_DOLLAR) begin
            res.verdict = nsf_pkg::VERDICT_NONE;
            res.astral  = line_now.count >= 8'd6 && nsf_pkg::is_astral(line_now.head);
        end
        else if (line_now.clen < nsf_pkg::MIN_CONTENT ||
                 line_now.tail[0] != nsf_pkg::CH_STAR) begin
            res.verdict = nsf_pkg::VERDICT_BAD;
        end
        else if (!hi[4] || !lo[4] || {hi[3:0], lo[3:0]} != sum) begin
            res.verdict = nsf_pkg::VERDICT_MISMATCH;
        end
        else begin
            res.verdict = nsf_pkg::VERDICT_OK;
            res.kind    = nsf_pkg::kind_of(line_now.head);
        end
    end

endmodule
